// ===== design/ils_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Command and status codes and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_READ    = 3'd4,
    CMD_COUNT   = 3'd5
  } ils_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ils_status_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } ils_ctrl_t;

endpackage

// ===== design/indexed_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store
// Fixed-capacity ordered list of words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// The command channel (in_valid/in_ready) carries one command per beat:
// append, insert at an index, remove at an index, replace, read or count.
// Every accepted beat yields exactly one result beat on out_valid/out_ready
// with a status, the word read (zero unless a read succeeds) and the number
// of entries held after the command.
// For each command, all cells shift or load in parallel in the accepting
// cycle, and the result appears in the output register on the next cycle.
// A new command is accepted every cycle while the result side keeps up;
// the rate is set by the single output register.
// When the receiver stalls, the result is held and in_ready drops until
// the result beat is taken.
// Reset empties the list and clears the pending result; entry contents are
// not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_index,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_word,
  output logic [4:0]  out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  out_valid_r;
  ils_status_t           out_status_r;
  logic [31:0]           out_read_word_r;
  logic [4:0]            out_entry_count_r;

  logic                  in_fire;
  ils_cmd_t              cmd;
  ils_ctrl_t             ctrl;
  ils_status_t           status_nxt;
  logic [POS_W-1:0]      idx_ext;
  logic [POS_W-1:0]      cnt_ext;
  logic [POS_W-1:0]      pos;
  logic                  in_range;
  logic                  full;
  logic                  rd_ok;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_or;

  logic [DATA_WIDTH-1:0] entry_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_bus  [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cmd      = ils_cmd_t'(in_command);
  assign idx_ext  = POS_W'(in_index);
  assign cnt_ext  = POS_W'(cnt_r);
  assign in_range = (idx_ext < cnt_ext);
  assign full     = (cnt_r == CNT_FULL);
  assign word     = DATA_WIDTH'(in_data_word);

  always_comb begin
    ctrl       = '0;
    status_nxt = ST_DONE;
    pos        = idx_ext;
    cnt_nxt    = cnt_r;
    rd_ok      = 1'b0;
    unique case (cmd)
      CMD_APPEND: begin
        pos = cnt_ext;
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (cnt_r == '0) begin
          pos      = cnt_ext;
          ctrl.ins = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.rem = 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.wr = 1'b1;
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      ctrl = '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = word;
    end else begin : g_mid_l
      assign left_w = entry_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_q[i+1];
    end
    ils_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_W      (POS_W),
      .POSITION   (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (pos),
      .word    (word),
      .left    (left_w),
      .right   (right_w),
      .entry   (entry_q[i]),
      .rd_word (rd_bus[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_bus[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r      <= status_nxt;
      out_read_word_r   <= rd_ok ? 32'(rd_or) : '0;
      out_entry_count_r <= 5'(cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_word   = out_read_word_r;
  assign out_entry_count = out_entry_count_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count exceeds capacity");

  a_fail_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (status_nxt != ST_DONE) |=> cnt_r == $past(cnt_r))
    else $error("failed command changed the entry count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_DONE || out_status_r == ST_RANGE ||
                     out_status_r == ST_FULL))
    else $error("result carries an unknown status");

  a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd != CMD_READ) |=> out_read_word_r == '0)
    else $error("non-read command returned a nonzero word");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_entry_count_r == 5'(cnt_r))
    else $error("reported entry count differs from held count");
`endif

endmodule

// ===== design/ils_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list entry and moves it to or from its neighbors on insert and
// remove; drives its entry onto the read bus when its position is selected.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 5,
  parameter int POSITION   = 0
) (
  input  logic                  clk,
  input  ils_ctrl_t             ctrl,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] entry,
  output logic [DATA_WIDTH-1:0] rd_word
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POSITION);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  at_pos;
  logic                  above_pos;

  assign at_pos    = (pos == MY_POS);
  assign above_pos = (MY_POS > pos);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (above_pos) begin
        entry_nxt = left;
      end else if (at_pos) begin
        entry_nxt = word;
      end
    end else if (ctrl.rem) begin
      if (above_pos || at_pos) begin
        entry_nxt = right;
      end
    end else if (ctrl.wr && at_pos) begin
      entry_nxt = word;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry   = entry_r;
  assign rd_word = at_pos ? entry_r : '0;

endmodule
